/* rtl/pcm2s32_pkg.sv */
// Package for the PCM byte to s32 sample converter.
// Holds the sample format codes, register indexes and the float conversion.
// No dependencies.
`default_nettype none

package pcm2s32_pkg;

    typedef enum logic [2:0] {
        FMT_U8  = 3'd0,
        FMT_S16 = 3'd1,
        FMT_S24 = 3'd2,
        FMT_S32 = 3'd3,
        FMT_F32 = 3'd4,
        FMT_R5  = 3'd5,
        FMT_R6  = 3'd6,
        FMT_R7  = 3'd7
    } fmt_t;

    localparam logic [1:0] REG_SAMPLE_FORMAT  = 2'd0;
    localparam logic [1:0] REG_BYTE_ORDER_BIG = 2'd1;

    localparam logic [23:0] SCALE_MANT = 24'hFF_FFFF;   // 2147483520 = 0xFFFFFF * 2^7
    localparam logic [31:0] SCALE_INT  = 32'd2147483520;

    // bytes per sample, minus one
    function automatic logic [1:0] last_pos(input fmt_t fmt);
        logic [1:0] r;
        begin
            unique case (fmt)
                FMT_U8:  r = 2'd0;
                FMT_S24: r = 2'd2;
                FMT_S32: r = 2'd3;
                FMT_F32: r = 2'd3;
                default: r = 2'd1;
            endcase
            return r;
        end
    endfunction

    // IEEE single: clamp to [-1,1], times 2147483520 rounded to single, truncated
    function automatic logic [31:0] float_to_s32(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [47:0] prod;
        logic [24:0] rnd;
        logic        top;
        logic        guard;
        logic        sticky;
        logic        lsb;
        logic signed [9:0] sh;
        logic [9:0]  rsh;
        logic [31:0] mag;
        begin
            sgn  = bits[31];
            ex   = bits[30:23];
            fr   = bits[22:0];
            prod = {1'b1, fr} * SCALE_MANT;
            top  = prod[47];
            if (top)
            begin
                lsb    = prod[24];
                guard  = prod[23];
                sticky = |prod[22:0];
                rnd    = {1'b0, prod[47:24]};
            end
            else
            begin
                lsb    = prod[23];
                guard  = prod[22];
                sticky = |prod[21:0];
                rnd    = {1'b0, prod[46:23]};
            end
            if (guard && (sticky || lsb))
                rnd = rnd + 25'd1;
            sh  = $signed({2'b00, ex}) + (top ? 10'sd24 : 10'sd23) - 10'sd143;
            rsh = 10'(-sh);
            if (sh >= 0)
                mag = 32'(rnd) << sh[2:0];
            else if (rsh > 10'd24)
                mag = 32'd0;
            else
                mag = 32'(rnd >> rsh[4:0]);
            if (ex == 8'hFF && fr != 23'd0)
                mag = 32'd0;
            else if (ex == 8'd0)
                mag = 32'd0;
            else if (ex > 8'd127 || (ex == 8'd127 && fr != 23'd0))
                mag = SCALE_INT;
            return sgn ? 32'(-mag) : mag;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/pcm_bytes_to_s32_converter_top.sv */
// Top level of the PCM byte to s32 sample converter.
// Depends on pcm2s32_pkg.
//
// channel | dir | beat
// s_*     | in  | tdata = data_byte[7:0], tlast = chunk_end
// m_*     | out | tdata = sample_value[31:0], tlast = last_of_chunk
// cfg_*   | in  | index 0 sample_format, 1 byte_order_big
//
// One byte per cycle sustained while m_tready stays high. A sample's last byte
// is reordered into a registered word, which is then converted into the
// output register that drives m_tvalid (the float path's 24x24 multiply sets
// that stage). Reset: s16, little-endian, nothing gathered. Stalls on m_tready
// back up through both registers to s_tready.
`default_nettype none

module pcm_bytes_to_s32_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // chunk_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // sample_value
    output logic             m_tlast,   // last_of_chunk
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);

    pcm2s32_pkg::fmt_t fmt_reg;
    logic        big_reg;
    logic [23:0] gath_reg, gath_next;
    logic [1:0]  pos_reg, pos_next;

    logic        a_valid_reg;
    logic [31:0] a_raw_reg;
    pcm2s32_pkg::fmt_t a_fmt_reg;
    logic        a_last_reg;

    logic        o_valid_reg;
    logic [31:0] o_data_reg;
    logic        o_last_reg;

    logic        out_free, a_free, in_acc, complete;
    logic [1:0]  npos;
    logic [31:0] arrived, raw, conv;

    assign out_free = !o_valid_reg || m_tready;
    assign a_free   = !a_valid_reg || out_free;
    assign s_tready = a_free;
    assign in_acc   = s_tvalid && a_free;
    assign npos     = pcm2s32_pkg::last_pos(fmt_reg);
    assign complete = (pos_reg == npos);
    assign arrived  = {gath_reg, s_tdata};

    always_comb
    begin
        unique case (npos)
            2'd0: raw = {24'd0, arrived[7:0]};
            2'd1: raw = big_reg ? {16'd0, arrived[15:0]}
                                : {16'd0, arrived[7:0], arrived[15:8]};
            2'd2: raw = big_reg ? {8'd0, arrived[23:0]}
                                : {8'd0, arrived[7:0], arrived[15:8], arrived[23:16]};
            default: raw = big_reg ? arrived
                                : {arrived[7:0], arrived[15:8], arrived[23:16], arrived[31:24]};
        endcase
    end

    always_comb
    begin
        gath_next = gath_reg;
        pos_next  = pos_reg;
        if (cfg_we && cfg_index == pcm2s32_pkg::REG_SAMPLE_FORMAT)
        begin
            gath_next = 24'd0;
            pos_next  = 2'd0;
        end
        else if (in_acc)
        begin
            if (complete || s_tlast)
            begin
                gath_next = 24'd0;
                pos_next  = 2'd0;
            end
            else
            begin
                gath_next = {gath_reg[15:0], s_tdata};
                pos_next  = pos_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        unique case (a_fmt_reg)
            pcm2s32_pkg::FMT_U8:  conv = {a_raw_reg[7:0] ^ 8'h80, 24'd0};
            pcm2s32_pkg::FMT_S24: conv = {a_raw_reg[23:0], 8'd0};
            pcm2s32_pkg::FMT_S32: conv = a_raw_reg;
            pcm2s32_pkg::FMT_F32: conv = pcm2s32_pkg::float_to_s32(a_raw_reg);
            default:              conv = {a_raw_reg[15:0], 16'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= pcm2s32_pkg::FMT_S16;
            big_reg     <= 1'b0;
            gath_reg    <= 24'd0;
            pos_reg     <= 2'd0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            gath_reg <= gath_next;
            pos_reg  <= pos_next;
            if (cfg_we && cfg_index == pcm2s32_pkg::REG_SAMPLE_FORMAT)
                fmt_reg <= pcm2s32_pkg::fmt_t'(cfg_data);
            if (cfg_we && cfg_index == pcm2s32_pkg::REG_BYTE_ORDER_BIG)
                big_reg <= cfg_data[0];
            if (in_acc && complete)
                a_valid_reg <= 1'b1;
            else if (out_free)
                a_valid_reg <= 1'b0;
            if (out_free)
                o_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && complete)
        begin
            a_raw_reg  <= raw;
            a_fmt_reg  <= fmt_reg;
            a_last_reg <= s_tlast;
        end
        if (out_free && a_valid_reg)
        begin
            o_data_reg <= conv;
            o_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

/* dv/pcm_bytes_to_s32_checker.sv */
// Scoreboard for the PCM byte to s32 converter: tracks register writes and input beats,
// predicts each output sample and compares it with the output channel.
// Depends on pcm2s32_pkg.
`timescale 1ns / 100ps

module pcm_bytes_to_s32_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // chunk_end
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // sample_value
    input  wire logic        m_tlast,   // last_of_chunk
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    output int               fails,
    output int               pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sample_t;

    sample_t     samples_due[$];
    pcm2s32_pkg::fmt_t fmt;
    logic        order_msb_first;
    logic [23:0] held_bytes;
    logic [1:0]  held_count;

    function automatic int sample_bytes(input pcm2s32_pkg::fmt_t f);
        case (f)
            pcm2s32_pkg::FMT_U8:  return 1;
            pcm2s32_pkg::FMT_S24: return 3;
            pcm2s32_pkg::FMT_S32: return 4;
            pcm2s32_pkg::FMT_F32: return 4;
            default: return 2;
        endcase
    endfunction

    // single-precision product with 2147483520, rounded to nearest even, cut toward zero
    function automatic logic [31:0] single_to_pcm(input logic [31:0] w);
        logic [47:0] p;
        logic [24:0] r;
        logic [63:0] mag;
        int          s;
        int          e;
        logic        g;
        logic        st;
        if (w[30:23] == 8'hFF && w[22:0] != 0)
            return 32'd0;
        if (w[30:23] == 8'd0)
            return 32'd0;
        if (w[30:23] > 8'd127 || (w[30:23] == 8'd127 && w[22:0] != 0))
            mag = 64'd2147483520;
        else
        begin
            p  = 48'({1'b1, w[22:0]}) * 48'hFF_FFFF;
            s  = p[47] ? 24 : 23;
            r  = 25'(p >> s);
            g  = p[s-1];
            st = (p & ((48'd1 << (s - 1)) - 48'd1)) != 0;
            if (g && (st || r[0]))
                r = r + 25'd1;
            e = int'(w[30:23]) - 143 + s;
            if (e >= 0)
                mag = 64'(r) << e;
            else if (-e >= 40)
                mag = 64'd0;
            else
                mag = 64'(r) >> (-e);
        end
        return w[31] ? -mag[31:0] : mag[31:0];
    endfunction

    function automatic sample_t build_sample(input logic [7:0] b, input logic l);
        sample_t     res;
        logic [31:0] arrived;
        logic [31:0] word;
        int          n;
        n = sample_bytes(fmt);
        arrived = {held_bytes, b};
        if (n < 4)
            arrived = arrived & ((32'd1 << (8 * n)) - 32'd1);
        word = 32'd0;
        if (order_msb_first)
            word = arrived;
        else
            for (int i = 0; i < n; i++)
                word = (word << 8) | ((arrived >> (8 * i)) & 32'hFF);
        case (fmt)
            pcm2s32_pkg::FMT_U8:  res.value = {word[7] ^ 1'b1, word[6:0], 24'd0};
            pcm2s32_pkg::FMT_S24: res.value = {word[23:0], 8'd0};
            pcm2s32_pkg::FMT_S32: res.value = word;
            pcm2s32_pkg::FMT_F32: res.value = single_to_pcm(word);
            default: res.value = {word[15:0], 16'd0};
        endcase
        res.last = l;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t got;
        sample_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            fmt             <= pcm2s32_pkg::FMT_S16;
            order_msb_first <= 1'b0;
            held_bytes      <= 24'd0;
            held_count      <= 2'd0;
            fails           <= 0;
            pending         <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index == pcm2s32_pkg::REG_SAMPLE_FORMAT)
            begin
                fmt        <= pcm2s32_pkg::fmt_t'(cfg_data);
                held_bytes <= 24'd0;
                held_count <= 2'd0;
            end
            else if (cfg_we && cfg_index == pcm2s32_pkg::REG_BYTE_ORDER_BIG)
                order_msb_first <= cfg_data[0];
            if (s_tvalid && s_tready)
            begin
                if (int'(held_count) + 1 < sample_bytes(fmt))
                begin
                    held_bytes <= s_tlast ? 24'd0 : {held_bytes[15:0], s_tdata};
                    held_count <= s_tlast ? 2'd0 : held_count + 2'd1;
                end
                else
                begin
                    samples_due.push_back(build_sample(s_tdata, s_tlast));
                    held_bytes <= 24'd0;
                    held_count <= 2'd0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata;
                got.last  = m_tlast;
                if (samples_due.size() == 0)
                begin
                    $error("unexpected beat: sample_value %h last_of_chunk %b",
                           got.value, got.last);
                    errs = errs + 1;
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("sample_value expected %h actual %h", want.value, got.value);
                        errs = errs + 1;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_of_chunk expected %b actual %b", want.last, got.last);
                        errs = errs + 1;
                    end
                end
            end
            fails   <= fails + errs;
            pending <= samples_due.size();
        end
    end

endmodule

/* dv/tb_pcm_bytes_to_s32_converter_top.sv */
// Testbench top for the PCM byte to s32 converter: clock, reset, directed and random
// byte streams under varied register settings; checking sits in pcm_bytes_to_s32_checker.
// Depends on pcm2s32_pkg, the converter RTL and the checker.
`timescale 1ns / 100ps

module tb_pcm_bytes_to_s32_converter_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [2:0]  cfg_data = 3'd0;
    int          fails;
    int          pending;
    int          burst_left = 0;
    int          beats_sent = 0;
    pcm2s32_pkg::fmt_t cur_fmt = pcm2s32_pkg::FMT_S16;
    logic        cur_big = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pcm_bytes_to_s32_converter_top uut (.*);

    pcm_bytes_to_s32_checker chk (.*);

    // receiver: stall style changes every so often
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 80);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left = burst_left - 1;
        beats_sent = beats_sent + 1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pcm2s32_pkg::REG_SAMPLE_FORMAT)
            cur_fmt = pcm2s32_pkg::fmt_t'(val);
        else if (idx == pcm2s32_pkg::REG_BYTE_ORDER_BIG)
            cur_big = val[0];
    endtask

    function automatic int width_of(input pcm2s32_pkg::fmt_t f);
        case (f)
            pcm2s32_pkg::FMT_U8:  return 1;
            pcm2s32_pkg::FMT_S24: return 3;
            pcm2s32_pkg::FMT_S32: return 4;
            pcm2s32_pkg::FMT_F32: return 4;
            default: return 2;
        endcase
    endfunction

    // sends one whole sample in the current byte order, tlast on its last byte if asked
    task automatic send_word(input logic [31:0] w, input logic l);
        int n;
        n = width_of(cur_fmt);
        for (int i = 0; i < n; i++)
            send_beat(cur_big ? 8'(w >> (8 * (n - 1 - i))) : 8'(w >> (8 * i)),
                      l && (i == n - 1));
    endtask

    initial
    begin
        logic [31:0] w;
        int          n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: s16 little-endian
        send_word(32'h0000_8000, 1'b0);
        send_word(32'h0000_7FFF, 1'b1);
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_U8);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b1);
        write_reg(pcm2s32_pkg::REG_BYTE_ORDER_BIG, 3'd1);
        send_beat(8'h7F, 1'b0);
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_S24);
        send_word(32'h0080_0000, 1'b0);
        send_word(32'h007F_FFFF, 1'b1);
        send_beat(8'h12, 1'b0);
        send_beat(8'h34, 1'b1);          // partial sample dropped at chunk end
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_F32);
        send_word(32'h3F80_0000, 1'b0);
        send_word(32'hBF80_0000, 1'b0);
        send_word(32'h4000_0000, 1'b0);
        send_word(32'h7FC0_0000, 1'b0);
        send_word(32'hFF80_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h3F00_0001, 1'b1);
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_S32);
        write_reg(pcm2s32_pkg::REG_BYTE_ORDER_BIG, 3'd0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_beat(8'hAA, 1'b0);
        write_reg(pcm2s32_pkg::REG_BYTE_ORDER_BIG, 3'd1);   // order change keeps gathered bytes
        send_beat(8'h55, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'hFE, 1'b0);
        send_beat(8'h99, 1'b0);
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_R5);  // drops the partial one
        send_word(32'h0000_1234, 1'b0);
        write_reg(2'd2, 3'd7);
        write_reg(2'd3, 3'd0);
        write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, pcm2s32_pkg::FMT_R7);
        send_word(32'h0000_FFFF, 1'b1);

        while (beats_sent < 550)
        begin
            write_reg(pcm2s32_pkg::REG_SAMPLE_FORMAT, 3'($urandom_range(0, 7)));
            write_reg(pcm2s32_pkg::REG_BYTE_ORDER_BIG, 3'($urandom_range(0, 1)));
            n = $urandom_range(4, 20);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(8'($urandom), 1'($urandom_range(0, 1)));
                else
                begin
                    w = $urandom;
                    if (cur_fmt == pcm2s32_pkg::FMT_F32 && $urandom_range(0, 3) != 0)
                        w[30:23] = 8'($urandom_range(100, 128));
                    send_word(w, $urandom_range(0, 5) == 0);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("tb_pcm_bytes_to_s32_converter_top passed");
        else
            $display("tb_pcm_bytes_to_s32_converter_top failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_pcm_bytes_to_s32_converter_top failed");
        $finish;
    end

endmodule
